FILE: rtl/core/point_in_triangle_mesh_hit_test_assert.svh
// Assertion macros for the point-in-triangle mesh hit test checker
`ifndef POINT_IN_TRIANGLE_MESH_HIT_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_MESH_HIT_TEST_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define PITM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also checks during reset
`define PITM_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pitm_pkg.sv
// Shared types and constants for the point-in-triangle mesh hit test
`timescale 1ns / 1ps

package pitm_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 37;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;
    localparam int EXT_W   = 17;

    localparam logic [1:0] CMD_WRITE_VERTEX   = 2'd0;
    localparam logic [1:0] CMD_WRITE_TRIANGLE = 2'd1;
    localparam logic [1:0] CMD_QUERY          = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef struct packed {
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] a;
    } tri_entry_t;

    typedef struct packed {
        diff_t abx;
        diff_t aby;
        diff_t acx;
        diff_t acy;
        diff_t apx;
        diff_t apy;
    } cross_operands_t;

    typedef struct packed {
        logic done;
        logic hit;
    } cross_status_t;

endpackage

FILE: rtl/core/pitm_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module pitm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/pitm_cross_unit.sv
// Shared multiplier and accumulator forming the three cross products and the hit decision
`timescale 1ns / 1ps

module pitm_cross_unit import pitm_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  cross_operands_t ops,
    output cross_status_t   status
);

    typedef enum logic [2:0] {
        STEP_ABX_ACY,
        STEP_ABY_ACX,
        STEP_ABX_APY,
        STEP_ABY_APX,
        STEP_APX_ACY,
        STEP_APY_ACX,
        STEP_APC,
        STEP_DECIDE
    } step_t;

    step_t                      step_reg;
    logic                       busy_reg;
    cross_status_t              status_reg;
    cross_operands_t            ops_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CROSS_W-1:0]  acc_reg;
    logic signed [CROSS_W-1:0]  abc_reg;
    logic signed [CROSS_W-1:0]  abp_reg;
    logic signed [CROSS_W-1:0]  apc_reg;

    diff_t                      mul_a;
    diff_t                      mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [CROSS_W-1:0]  diff_acc;
    logic signed [CROSS_W-1:0]  pbc;
    logic                       hit;

    always_comb begin
        unique case (step_reg)
            STEP_ABX_ACY: begin mul_a = ops_reg.abx; mul_b = ops_reg.acy; end
            STEP_ABY_ACX: begin mul_a = ops_reg.aby; mul_b = ops_reg.acx; end
            STEP_ABX_APY: begin mul_a = ops_reg.abx; mul_b = ops_reg.apy; end
            STEP_ABY_APX: begin mul_a = ops_reg.aby; mul_b = ops_reg.apx; end
            STEP_APX_ACY: begin mul_a = ops_reg.apx; mul_b = ops_reg.acy; end
            STEP_APY_ACX: begin mul_a = ops_reg.apy; mul_b = ops_reg.acx; end
            default:      begin mul_a = ops_reg.abx; mul_b = ops_reg.acy; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign diff_acc = acc_reg - CROSS_W'(prod_reg);
    assign pbc      = abc_reg - abp_reg - apc_reg;

    // same sign as the area, zero counting as either
    always_comb begin
        if (!abc_reg[CROSS_W-1]) begin
            hit = !abp_reg[CROSS_W-1] && !apc_reg[CROSS_W-1] && !pbc[CROSS_W-1];
        end else begin
            hit = (abp_reg[CROSS_W-1] || (abp_reg == '0))
               && (apc_reg[CROSS_W-1] || (apc_reg == '0))
               && (pbc[CROSS_W-1] || (pbc == '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= STEP_ABX_ACY;
            status_reg <= '0;
        end else begin
            status_reg.done <= !start && busy_reg && (step_reg == STEP_DECIDE);
            if (start) begin
                ops_reg  <= ops;
                busy_reg <= 1'b1;
                step_reg <= STEP_ABX_ACY;
            end else if (busy_reg) begin
                prod_reg <= prod;
                unique case (step_reg)
                    STEP_ABX_ACY: begin
                        step_reg <= STEP_ABY_ACX;
                    end
                    STEP_ABY_ACX: begin
                        acc_reg  <= CROSS_W'(prod_reg);
                        step_reg <= STEP_ABX_APY;
                    end
                    STEP_ABX_APY: begin
                        abc_reg  <= diff_acc;
                        step_reg <= STEP_ABY_APX;
                    end
                    STEP_ABY_APX: begin
                        acc_reg  <= CROSS_W'(prod_reg);
                        step_reg <= STEP_APX_ACY;
                    end
                    STEP_APX_ACY: begin
                        abp_reg  <= diff_acc;
                        step_reg <= STEP_APY_ACX;
                    end
                    STEP_APY_ACX: begin
                        acc_reg  <= CROSS_W'(prod_reg);
                        step_reg <= STEP_APC;
                    end
                    STEP_APC: begin
                        apc_reg  <= diff_acc;
                        step_reg <= STEP_DECIDE;
                    end
                    STEP_DECIDE: begin
                        status_reg.hit  <= hit;
                        busy_reg        <= 1'b0;
                        step_reg        <= STEP_ABX_ACY;
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        step_reg <= STEP_ABX_ACY;
                    end
                endcase
            end
        end
    end

    assign status = status_reg;

endmodule

FILE: rtl/core/point_in_triangle_mesh_hit_test.sv
// Point-in-triangle mesh hit test: tables, sequencer and result register
//
// Input words arrive on s_tvalid/s_tready/s_tdata with the command on s_tuser.
// Vertex and triangle writes update their tables in the cycle of acceptance
// and give no result; the block is ready again in the next cycle.
// A query walks triangles from slot 0 up to the triangle count (capped at the
// table depth) and stops at the first hit. Each triangle takes one triangle
// read, the corner reads on the single vertex RAM read port, eight steps of
// the shared 17x17 multiplier and accumulator, and one hand-back. s_tready is
// low for the whole query.
// The single result word goes to an output register on m_tvalid/m_tready;
// input writes are still taken while it waits. A finished query holds until
// the output register is free, so a stalled receiver stalls further queries.
// Reset clears the sequencer, the output valid and the triangle count; table
// contents are not cleared and must be written before being queried.
// cfg_wr_en writes the triangle count from cfg_wr_data; use it only while the
// block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module point_in_triangle_mesh_hit_test import pitm_pkg::*; #(
    parameter int VERTEX_DEPTH   = 256,
    parameter int TRIANGLE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // slot[7:0], coord_x[23:8], coord_y[39:24], corner_a[47:40],
    // corner_b[55:48], corner_c[63:56]
    input  logic [63:0]        s_tdata,
    // cmd[1:0]
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // inside_res[0], zeros above
    output logic [7:0]         m_tdata
);

    localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int TAW = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
    localparam logic [EXT_W-1:0] VDEPTH = EXT_W'(VERTEX_DEPTH);
    localparam logic [EXT_W-1:0] TDEPTH = EXT_W'(TRIANGLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRI,
        ST_VA,
        ST_VB,
        ST_VC,
        ST_VD,
        ST_CROSS,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   tri_count_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [COUNT_W-1:0]   tri_idx_reg;
    logic                 hit_reg;
    logic                 m_tvalid_reg;
    logic                 inside_reg;
    logic                 oob_reg;
    tri_entry_t           corners_reg;
    coord_t               px_reg;
    coord_t               py_reg;
    coord_t               ax_reg;
    coord_t               ay_reg;
    coord_t               bx_reg;
    coord_t               by_reg;

    logic [IDX_W-1:0]     slot;
    coord_t               coord_x;
    coord_t               coord_y;
    tri_entry_t           tri_wr;
    logic                 accept;
    logic                 out_load;
    logic [EXT_W-1:0]     slot_ext;
    logic [EXT_W-1:0]     count_ext;
    logic [COUNT_W-1:0]   n_calc;

    logic                 vram_wr_en;
    logic                 tram_wr_en;
    logic [2*COORD_W-1:0] vram_rdata;
    tri_entry_t           tram_rdata;
    logic [IDX_W-1:0]     vrd_corner;
    logic [EXT_W-1:0]     vrd_ext;
    logic                 vrd_oob;
    logic [EXT_W-1:0]     tri_idx_ext;

    coord_t               vx;
    coord_t               vy;
    coord_t               cx;
    coord_t               cy;
    logic                 cross_start;
    cross_operands_t      cross_ops;
    cross_status_t        cross_status;

    assign slot    = s_tdata[7:0];
    assign coord_x = s_tdata[23:8];
    assign coord_y = s_tdata[39:24];
    assign tri_wr  = '{c: s_tdata[63:56], b: s_tdata[55:48], a: s_tdata[47:40]};

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign slot_ext  = EXT_W'(slot);
    assign count_ext = EXT_W'(tri_count_reg);
    assign n_calc    = (count_ext > TDEPTH) ? COUNT_W'(TDEPTH) : tri_count_reg;

    assign vram_wr_en = accept && (s_tuser == CMD_WRITE_VERTEX) && (slot_ext < VDEPTH);
    assign tram_wr_en = accept && (s_tuser == CMD_WRITE_TRIANGLE) && (slot_ext < TDEPTH);

    always_comb begin
        unique case (state_reg)
            ST_VA:   vrd_corner = tram_rdata.a;
            ST_VB:   vrd_corner = corners_reg.b;
            ST_VC:   vrd_corner = corners_reg.c;
            default: vrd_corner = '0;
        endcase
    end

    assign vrd_ext     = EXT_W'(vrd_corner);
    assign vrd_oob     = (vrd_ext >= VDEPTH);
    assign tri_idx_ext = EXT_W'(tri_idx_reg);

    pitm_ram #(
        .WIDTH (2*COORD_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .aclk    (aclk),
        .wr_en   (vram_wr_en),
        .wr_addr (slot_ext[VAW-1:0]),
        .wr_data ({coord_y, coord_x}),
        .rd_addr (vrd_ext[VAW-1:0]),
        .rd_data (vram_rdata)
    );

    pitm_ram #(
        .WIDTH (3*IDX_W),
        .DEPTH (TRIANGLE_DEPTH)
    ) u_triangle_ram (
        .aclk    (aclk),
        .wr_en   (tram_wr_en),
        .wr_addr (slot_ext[TAW-1:0]),
        .wr_data (tri_wr),
        .rd_addr (tri_idx_ext[TAW-1:0]),
        .rd_data (tram_rdata)
    );

    // corner beyond the vertex table reads as the origin
    assign vx = oob_reg ? '0 : vram_rdata[COORD_W-1:0];
    assign vy = oob_reg ? '0 : vram_rdata[2*COORD_W-1:COORD_W];
    assign cx = vx;
    assign cy = vy;

    assign cross_start   = (state_reg == ST_VD);
    assign cross_ops.abx = {bx_reg[COORD_W-1], bx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign cross_ops.aby = {by_reg[COORD_W-1], by_reg} - {ay_reg[COORD_W-1], ay_reg};
    assign cross_ops.acx = {cx[COORD_W-1], cx} - {ax_reg[COORD_W-1], ax_reg};
    assign cross_ops.acy = {cy[COORD_W-1], cy} - {ay_reg[COORD_W-1], ay_reg};
    assign cross_ops.apx = {px_reg[COORD_W-1], px_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign cross_ops.apy = {py_reg[COORD_W-1], py_reg} - {ay_reg[COORD_W-1], ay_reg};

    pitm_cross_unit u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cross_start),
        .ops     (cross_ops),
        .status  (cross_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tri_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tri_count_reg <= cfg_wr_data;
            end
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_tuser == CMD_QUERY)) begin
                        px_reg      <= coord_x;
                        py_reg      <= coord_y;
                        hit_reg     <= 1'b0;
                        tri_idx_reg <= '0;
                        n_reg       <= n_calc;
                        state_reg   <= (n_calc == '0) ? ST_FINISH : ST_TRI;
                    end
                end
                ST_TRI: begin
                    state_reg <= ST_VA;
                end
                ST_VA: begin
                    corners_reg <= tram_rdata;
                    oob_reg     <= vrd_oob;
                    state_reg   <= ST_VB;
                end
                ST_VB: begin
                    ax_reg    <= vx;
                    ay_reg    <= vy;
                    oob_reg   <= vrd_oob;
                    state_reg <= ST_VC;
                end
                ST_VC: begin
                    bx_reg    <= vx;
                    by_reg    <= vy;
                    oob_reg   <= vrd_oob;
                    state_reg <= ST_VD;
                end
                ST_VD: begin
                    state_reg <= ST_CROSS;
                end
                ST_CROSS: begin
                    if (cross_status.done) begin
                        if (cross_status.hit) begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else if ((tri_idx_reg + COUNT_W'(1)) == n_reg) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            tri_idx_reg <= tri_idx_reg + COUNT_W'(1);
                            state_reg   <= ST_TRI;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        inside_reg   <= hit_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, inside_reg};

endmodule

FILE: rtl/core/pitm_checker.sv
// Port-level checker for the point-in-triangle mesh hit test, bound to the top level
`timescale 1ns / 1ps
`include "point_in_triangle_mesh_hit_test_assert.svh"

module pitm_checker import pitm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [1:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [7:0]         m_tdata
);

    `PITM_ASSERT_NORST(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid,
        "result word valid after reset")

    `PITM_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result word changed")

    `PITM_ASSERT(a_write_one_cycle, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser != CMD_QUERY) |=> s_tready,
        "not ready after a table write")

    `PITM_ASSERT(a_query_busy, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready,
        "ready in the cycle after a query")

endmodule

bind point_in_triangle_mesh_hit_test pitm_checker u_pitm_checker (.*);
